// File: rtl/butterworth_lowpass_order4_core_assert.svh
`ifndef BUTTERWORTH_LOWPASS_ORDER4_CORE_ASSERT_SVH
`define BUTTERWORTH_LOWPASS_ORDER4_CORE_ASSERT_SVH

// Same-cycle implication, checked on every rising edge of clk outside reset.
`define BWLP4_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("bwlp4 assertion failed");

// Next-cycle implication, checked on every rising edge of clk outside reset.
`define BWLP4_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("bwlp4 assertion failed");

`endif

// File: rtl/bwlp4_pkg.sv
package bwlp4_pkg;

	localparam int SAMPLE_W = 24;
	localparam int STATE_W = 48;
	localparam int TAPS = 4;

	localparam int COEF_W = 40;
	localparam int COEF_FRAC = 36;
	localparam int C_LO_W = 20;
	localparam int C_HI_W = COEF_W - C_LO_W;
	localparam int Y_LO_W = 24;
	localparam int Y_HI_W = STATE_W - Y_LO_W;
	localparam int PROD_W = COEF_W + STATE_W;

	localparam int FF_W = SAMPLE_W + 4;
	localparam int RECIP_W = 33;
	localparam int FFP_W = FF_W + RECIP_W;
	localparam int FF_ALIGN = 8;
	localparam int ACC_W = PROD_W + 2;

	localparam int OUT_SHIFT = STATE_W - 4 - (SAMPLE_W - 1);

	typedef logic signed [SAMPLE_W-1:0] sample_t;
	typedef logic signed [STATE_W-1:0] state_t;
	typedef logic signed [COEF_W-1:0] coef_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [FF_W-1:0] ff_t;
	typedef logic signed [FFP_W-1:0] ffp_t;
	typedef logic signed [ACC_W-1:0] acc_t;

	localparam logic signed [RECIP_W-1:0] RECIP = 33'sd3065691722;

	localparam coef_t FB_COEF [TAPS] = '{
		-40'sd52946969922,
		40'sd225583898180,
		-40'sd360895596757,
		40'sd256972157549
	};

	localparam acc_t STATE_RND = acc_t'(1) << (COEF_FRAC - 1);
	localparam logic signed [STATE_W:0] OUT_RND = (STATE_W + 1)'(1) << (OUT_SHIFT - 1);

	localparam state_t STATE_MAX = {1'b0, {(STATE_W - 1){1'b1}}};
	localparam state_t STATE_MIN = {1'b1, {(STATE_W - 1){1'b0}}};
	localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_W - 1){1'b1}}};
	localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_W - 1){1'b0}}};

	typedef struct packed {
		logic take_in;
		logic load_s2;
	} bwlp4_ff_ctl_t;

	typedef struct packed {
		logic start;
		logic sum;
		logic shift;
	} bwlp4_cell_ctl_t;

endpackage

// File: rtl/bwlp4_feedforward.sv
module bwlp4_feedforward import bwlp4_pkg::*; (
	input logic clk,
	input logic arst_n,
	input bwlp4_ff_ctl_t ctl,
	input sample_t sample_in,
	output ffp_t ff_prod
);

	sample_t x_q [TAPS];
	ff_t ff_s1;
	ffp_t ffp_s2;
	ff_t ff_sum;
	ff_t x2_ext;

	assign x2_ext = ff_t'(x_q[2]);

	always_comb begin
		ff_sum = (ff_t'(x_q[0]) + ff_t'(sample_in))
			+ ((ff_t'(x_q[1]) + ff_t'(x_q[3])) <<< 2)
			+ (x2_ext <<< 2) + (x2_ext <<< 1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < TAPS; i++) begin
				x_q[i] <= '0;
			end
		end else if (ctl.take_in) begin
			for (int i = 0; i < TAPS - 1; i++) begin
				x_q[i] <= x_q[i + 1];
			end
			x_q[TAPS - 1] <= sample_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.take_in) begin
			ff_s1 <= ff_sum;
		end
		if (ctl.load_s2) begin
			ffp_s2 <= ffp_t'(ff_s1) * ffp_t'(RECIP);
		end
	end

	assign ff_prod = ffp_s2;

endmodule

// File: rtl/bwlp4_tap_cell.sv
module bwlp4_tap_cell import bwlp4_pkg::*; (
	input logic clk,
	input logic arst_n,
	input bwlp4_cell_ctl_t ctl,
	input coef_t coef,
	input state_t y_in,
	output state_t y,
	output prod_t prod
);

	state_t y_q;
	logic signed [C_HI_W-1:0] c_hi;
	logic signed [C_LO_W:0] c_lo;
	logic signed [Y_HI_W-1:0] y_hi;
	logic signed [Y_LO_W:0] y_lo;
	logic signed [C_HI_W+Y_HI_W-1:0] pp_hh_s3;
	logic signed [C_HI_W+Y_LO_W:0] pp_hl_s3;
	logic signed [C_LO_W+Y_HI_W:0] pp_lh_s3;
	logic signed [C_LO_W+Y_LO_W+1:0] pp_ll_s3;
	prod_t prod_s4;

	assign c_hi = coef[COEF_W-1:C_LO_W];
	assign c_lo = {1'b0, coef[C_LO_W-1:0]};
	assign y_hi = y_q[STATE_W-1:Y_LO_W];
	assign y_lo = {1'b0, y_q[Y_LO_W-1:0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			y_q <= '0;
		end else if (ctl.shift) begin
			y_q <= y_in;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			pp_hh_s3 <= c_hi * y_hi;
			pp_hl_s3 <= c_hi * y_lo;
			pp_lh_s3 <= c_lo * y_hi;
			pp_ll_s3 <= c_lo * y_lo;
		end
		if (ctl.sum) begin
			prod_s4 <= (prod_t'(pp_hh_s3) <<< (C_LO_W + Y_LO_W))
				+ (prod_t'(pp_hl_s3) <<< C_LO_W)
				+ (prod_t'(pp_lh_s3) <<< Y_LO_W)
				+ prod_t'(pp_ll_s3);
		end
	end

	assign y = y_q;
	assign prod = prod_s4;

endmodule

// File: rtl/butterworth_lowpass_order4_core.sv
// Channel  Handshake            Payload
// in       in_valid, in_ready   sample_in (24-bit signed)
// out      out_valid, out_ready sample_out (24-bit signed), clipped
//
// A beat is taken on in every cycle while the two entry stages have room; the
// sustained rate is set by the output recursion (partial products, tap
// products, pair sums, accumulate and round), which takes one beat at a time.
// An accepted in beat passes s1 to s6 and the output register to out_valid.
// Reset clears the input and output history to zero at once.
// A stalled out channel holds the result; up to four beats wait inside.

`include "butterworth_lowpass_order4_core_assert.svh"

module butterworth_lowpass_order4_core import bwlp4_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input sample_t sample_in,
	output logic out_valid,
	input logic out_ready,
	output sample_t sample_out,
	output logic clipped
);

	logic valid_s1;
	logic valid_s2;
	logic valid_s3;
	logic valid_s4;
	logic valid_s5;
	logic valid_s6;
	logic out_valid_q;

	logic take_in;
	logic move1;
	logic ready2;
	logic start;
	logic fin;
	logic ready6;
	logic move6;
	logic out_take;

	bwlp4_ff_ctl_t ff_ctl;
	bwlp4_cell_ctl_t cell_ctl;
	ffp_t ff_prod;
	state_t tap_y [TAPS];
	prod_t tap_prod [TAPS];

	acc_t ffr_s3;
	acc_t ffr_s4;
	acc_t pa_s5;
	acc_t pb_s5;
	state_t y_s6;
	logic clip_s6;
	sample_t sample_out_q;
	logic clipped_q;

	acc_t acc_sum;
	logic [ACC_W-COEF_FRAC-1:0] acc_hi;
	logic state_fit;
	state_t y_new;
	logic signed [STATE_W:0] y_rnd;
	logic [STATE_W-OUT_SHIFT:0] y_shr;
	logic out_fit;
	sample_t sample_next;
	logic clip_next;

	assign out_take = out_valid_q && out_ready;
	assign move6 = valid_s6 && (!out_valid_q || out_ready);
	assign ready6 = !valid_s6 || move6;
	assign fin = valid_s5 && ready6;
	assign start = valid_s2 && !(valid_s3 || valid_s4 || valid_s5);
	assign ready2 = !valid_s2 || start;
	assign move1 = valid_s1 && ready2;
	assign in_ready = !valid_s1 || move1;
	assign take_in = in_valid && in_ready;

	assign ff_ctl = '{take_in: take_in, load_s2: move1};
	assign cell_ctl = '{start: start, sum: valid_s3, shift: fin};

	bwlp4_feedforward u_ff (
		.clk(clk),
		.arst_n(arst_n),
		.ctl(ff_ctl),
		.sample_in(sample_in),
		.ff_prod(ff_prod)
	);

	for (genvar k = 0; k < TAPS; k++) begin : g_tap
		state_t y_next;
		if (k == TAPS - 1) begin : g_last
			assign y_next = y_new;
		end else begin : g_mid
			assign y_next = tap_y[k + 1];
		end
		bwlp4_tap_cell u_cell (
			.clk(clk),
			.arst_n(arst_n),
			.ctl(cell_ctl),
			.coef(FB_COEF[k]),
			.y_in(y_next),
			.y(tap_y[k]),
			.prod(tap_prod[k])
		);
	end

	always_comb begin
		acc_sum = pa_s5 + pb_s5;
		acc_hi = acc_sum[ACC_W-1:COEF_FRAC];
		state_fit = (&acc_hi[ACC_W-COEF_FRAC-1:STATE_W-1])
			|| !(|acc_hi[ACC_W-COEF_FRAC-1:STATE_W-1]);
		if (state_fit) begin
			y_new = acc_hi[STATE_W-1:0];
		end else begin
			y_new = acc_sum[ACC_W-1] ? STATE_MIN : STATE_MAX;
		end
	end

	always_comb begin
		y_rnd = {y_s6[STATE_W-1], y_s6} + OUT_RND;
		y_shr = y_rnd[STATE_W:OUT_SHIFT];
		out_fit = (&y_shr[STATE_W-OUT_SHIFT:SAMPLE_W-1])
			|| !(|y_shr[STATE_W-OUT_SHIFT:SAMPLE_W-1]);
		if (out_fit) begin
			sample_next = y_shr[SAMPLE_W-1:0];
		end else begin
			sample_next = y_rnd[STATE_W] ? SAMPLE_MIN : SAMPLE_MAX;
		end
		clip_next = !out_fit || clip_s6;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= take_in || (valid_s1 && !move1);
			valid_s2 <= move1 || (valid_s2 && !start);
			valid_s3 <= start;
			valid_s4 <= valid_s3;
			valid_s5 <= valid_s4 || (valid_s5 && !fin);
			valid_s6 <= fin || (valid_s6 && !move6);
			out_valid_q <= move6 || (out_valid_q && !out_take);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			ffr_s3 <= (acc_t'(ff_prod) <<< FF_ALIGN) + STATE_RND;
		end
		if (valid_s3) begin
			ffr_s4 <= ffr_s3;
		end
		if (valid_s4) begin
			pa_s5 <= acc_t'(tap_prod[0]) + acc_t'(tap_prod[1]);
			pb_s5 <= acc_t'(tap_prod[2]) + acc_t'(tap_prod[3]) + ffr_s4;
		end
		if (fin) begin
			y_s6 <= y_new;
			clip_s6 <= !state_fit;
		end
		if (move6) begin
			sample_out_q <= sample_next;
			clipped_q <= clip_next;
		end
	end

	assign out_valid = out_valid_q;
	assign sample_out = sample_out_q;
	assign clipped = clipped_q;

	`BWLP4_ASSERT_NOW(a_loop_single, 1'b1, $onehot0({valid_s3, valid_s4, valid_s5}))
	`BWLP4_ASSERT_NEXT(a_loop_advance, valid_s3, valid_s4)
	`BWLP4_ASSERT_NOW(a_clip_saturates, out_valid_q && clipped_q, (sample_out_q == SAMPLE_MAX) || (sample_out_q == SAMPLE_MIN))

endmodule

// File: test/tb_butterworth_lowpass_order4_core.sv
`timescale 1ns / 1ps

module tb_butterworth_lowpass_order4_core;
	import bwlp4_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int FB_FRAC = 36;
	localparam int RECIP_FRAC = 49;
	localparam int FF_SHIFT = (STATE_W - 4) + FB_FRAC - (SAMPLE_W - 1 + RECIP_FRAC);
	localparam int SAMPLE_SHIFT = STATE_W - 4 - (SAMPLE_W - 1);
	localparam logic signed [127:0] GAIN_RECIP =
		((128'sd1 <<< RECIP_FRAC) * 10000 + 918145078) / 1836290157;

	typedef enum int {SEG_NOISE, SEG_TRIANGLE, SEG_SQUARE, SEG_QUIET} seg_kind_e;

	class filtered_board;
		typedef struct packed {
			sample_t value;
			logic clip;
		} filtered_t;

		logic signed [SAMPLE_W-1:0] hist_x[TAPS];
		logic signed [STATE_W-1:0] hist_y[TAPS];
		filtered_t expected_q[$];
		int errors = 0;
		int checked = 0;
		int clips = 0;

		function new();
			foreach (hist_x[i]) begin
				hist_x[i] = '0;
				hist_y[i] = '0;
			end
		endfunction

		function int waiting();
			return expected_q.size();
		endfunction

		function logic signed [127:0] saturate_round(input logic signed [127:0] v,
				input int sh, input int bits, output bit clip);
			logic signed [127:0] r, top, bottom;
			r = (v + (128'sd1 <<< (sh - 1))) >>> sh;
			top = (128'sd1 <<< (bits - 1)) - 1;
			bottom = -top - 1;
			clip = 1'b0;
			if (r > top) begin
				clip = 1'b1;
				r = top;
			end else if (r < bottom) begin
				clip = 1'b1;
				r = bottom;
			end
			return r;
		endfunction

		function void take_sample(sample_t x);
			logic signed [127:0] x0, x1, x2, x3, x4, y0, y1, y2, y3;
			logic signed [127:0] ff, acc, ynew, s;
			bit clip_state, clip_out;
			filtered_t res;
			x0 = hist_x[0];
			x1 = hist_x[1];
			x2 = hist_x[2];
			x3 = hist_x[3];
			x4 = x;
			y0 = hist_y[0];
			y1 = hist_y[1];
			y2 = hist_y[2];
			y3 = hist_y[3];
			ff = (x0 + x4) + 4 * (x1 + x3) + 6 * x2;
			acc = (ff * GAIN_RECIP) <<< FF_SHIFT;
			acc = acc + (-128'sd52946969922) * y0 + 128'sd225583898180 * y1
				+ (-128'sd360895596757) * y2 + 128'sd256972157549 * y3;
			ynew = saturate_round(acc, FB_FRAC, STATE_W, clip_state);
			s = saturate_round(ynew, SAMPLE_SHIFT, SAMPLE_W, clip_out);
			for (int i = 0; i < TAPS - 1; i++) begin
				hist_x[i] = hist_x[i + 1];
				hist_y[i] = hist_y[i + 1];
			end
			hist_x[TAPS - 1] = x;
			hist_y[TAPS - 1] = ynew[STATE_W-1:0];
			res.value = s[SAMPLE_W-1:0];
			res.clip = clip_state | clip_out;
			expected_q.push_back(res);
		endfunction

		function void compare_filtered(sample_t got, logic got_clip);
			filtered_t want;
			if (expected_q.size() == 0) begin
				$error("sample_out beat with no expected result: %0d", got);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (want.clip)
				clips++;
			if (got !== want.value) begin
				$error("sample_out: expected %0d, got %0d", want.value, got);
				errors++;
			end
			if (got_clip !== want.clip) begin
				$error("clipped: expected %0b, got %0b", want.clip, got_clip);
				errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	sample_t sample_in;
	logic out_valid;
	logic out_ready;
	sample_t sample_out;
	logic clipped;

	filtered_board board;
	int cycles = 0;
	int sent = 0;
	bit hold_request = 1'b0;
	bit steady = 1'b0;

	butterworth_lowpass_order4_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample_in(sample_in),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sample_out(sample_out),
		.clipped(clipped)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.take_sample(sample_in);
			if (out_valid && out_ready)
				board.compare_filtered(sample_out, clipped);
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(99);
		if (r < 80)
			return $urandom_range(3, 1);
		else if (r < 95)
			return $urandom_range(12, 4);
		return $urandom_range(60, 20);
	endfunction

	task automatic send_sample(input sample_t x);
		int gap;
		in_valid <= 1'b1;
		sample_in <= x;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		sent++;
		gap = (steady || $urandom_range(99) < 55) ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic drain(input int settle);
		in_valid <= 1'b0;
		@(posedge clk);
		while (board.waiting() != 0)
			@(posedge clk);
		repeat (settle) @(posedge clk);
	endtask

	initial begin
		int n;
		out_ready = 1'b0;
		@(posedge clk);
		while (!arst_n)
			@(posedge clk);
		forever begin
			if (hold_request) begin
				out_ready <= 1'b0;
				repeat (200) @(posedge clk);
				hold_request = 1'b0;
				out_ready <= 1'b1;
			end else if (steady || $urandom_range(99) < 65) begin
				out_ready <= 1'b1;
			end else begin
				n = pick_gap();
				out_ready <= 1'b0;
				repeat (n) @(posedge clk);
				out_ready <= 1'b1;
			end
			@(posedge clk);
		end
	end

	initial begin
		int seg_len, level, step, amp, period, random_sent;
		seg_kind_e kind;
		sample_t v;
		board = new();
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample_in = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Extremes first, then full-scale steps in both directions to drive overshoot.
		send_sample('0);
		send_sample(SAMPLE_MAX);
		send_sample(SAMPLE_MIN);
		send_sample(-24'sd1);
		send_sample(24'sd1);
		send_sample(24'sh555555);
		send_sample(24'shAAAAAA);
		repeat (8) send_sample(SAMPLE_MAX);
		repeat (8) send_sample(SAMPLE_MIN);
		drain(12);

		// The receiver stalls long while a back-to-back burst fills the pipeline.
		hold_request = 1'b1;
		steady = 1'b1;
		repeat (24) send_sample(sample_t'($urandom));
		steady = 1'b0;

		random_sent = 0;
		level = 0;
		step = 1000;
		while (random_sent < 540) begin
			kind = seg_kind_e'($urandom_range(3));
			seg_len = $urandom_range(40, 10);
			steady = ($urandom_range(9) == 0);
			period = $urandom_range(30, 6);
			amp = ($urandom_range(1) == 0) ? 8388607 : $urandom_range(8388607, 4000000);
			step = $urandom_range(300000, 1000);
			if ($urandom_range(1) == 0)
				step = -step;
			for (int k = 0; k < seg_len; k++) begin
				case (kind)
					SEG_NOISE: begin
						v = sample_t'($urandom);
					end
					SEG_TRIANGLE: begin
						level = level + step;
						if (level > 8388607) begin
							level = 8388607;
							step = -step;
						end else if (level < -8388608) begin
							level = -8388608;
							step = -step;
						end
						v = sample_t'(level);
					end
					SEG_SQUARE: begin
						v = sample_t'(((k / period) % 2) ? -amp - 1 : amp);
					end
					default: begin
						v = sample_t'(int'($urandom_range(64)) - 32);
					end
				endcase
				send_sample(v);
			end
			random_sent += seg_len;
			if (random_sent >= 300 && random_sent - seg_len < 300) begin
				steady = 1'b0;
				drain(12);
			end
		end
		steady = 1'b0;
		drain(20);

		$display("Filtered %0d samples: extremes, full-scale steps, triangle, square and noise runs.",
			sent);
		$display("Compared %0d results, %0d of them saturated.", board.checked, board.clips);
		if (board.errors == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// File: filelist.f
+incdir+rtl
rtl/bwlp4_pkg.sv
rtl/bwlp4_feedforward.sv
rtl/bwlp4_tap_cell.sv
rtl/butterworth_lowpass_order4_core.sv
test/tb_butterworth_lowpass_order4_core.sv
